[sv/tzdl_pkg.sv]
// Shared types and constants for the TZSP decapsulator with loop filter.
// No dependencies; imported by every module of the block.
`default_nettype none

package tzdl_pkg;

  localparam int COUNT_WIDTH_DEF  = 32;
  localparam int MAX_DATAGRAM_DEF = 65535;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int SHOW_W      = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_LOOP_PORT      = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LOOP_FILTER_ON = 1'd1;

  localparam logic [15:0] LOOP_PORT_RST      = 16'd37008;
  localparam logic        LOOP_FILTER_ON_RST = 1'b1;

  localparam logic [7:0]  TZSP_VERSION   = 8'd1;
  localparam logic [7:0]  TZSP_TYPE_MAX  = 8'd1;
  localparam logic [6:0]  HDR_LAST_IDX   = 7'd3;
  localparam logic [7:0]  TAG_PAD        = 8'd0;
  localparam logic [7:0]  TAG_END        = 8'd1;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  IP_PROTO_UDP   = 8'd17;
  localparam logic [15:0] MIN_UDP_FRAME  = 16'd34;
  localparam logic [3:0]  IHL_MASK       = 4'hF;
  localparam logic [6:0]  ETH_HDR_LEN    = 7'd14;
  localparam logic [6:0]  IDX_ETYPE_HI   = 7'd12;
  localparam logic [6:0]  IDX_ETYPE_LO   = 7'd13;
  localparam logic [6:0]  IDX_IHL        = 7'd14;
  localparam logic [6:0]  IDX_PROTO      = 7'd23;

  typedef enum logic [2:0] {
    V_FORWARD   = 3'd0,
    V_FILTERED  = 3'd1,
    V_SHORT     = 3'd2,
    V_VERSION   = 3'd3,
    V_TYPE      = 3'd4,
    V_MALFORMED = 3'd5,
    V_EMPTY     = 3'd6
  } verdict_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_valid;
    logic       datagram_done;
    verdict_t   verdict;
  } tzdl_res_t;

  typedef struct packed {
    logic fwd;
    logic filt;
  } tzdl_evt_t;

endpackage

`default_nettype wire

[sv/tzsp_decapsulator_loop_filter.sv]
// Path: an accepted byte is held in the input register, then passes through one
// step of the parse logic into the result register, which drives the outputs.
// Throughput: one byte per cycle unless out_stall holds a result word; the
// input register and the result register each hold one word, so a byte is
// taken while a finished word waits.
// Reset (synchronous, rst_n low): both registers empty, parse state at header byte
// zero, counters zero, listen port 37008, loop filter on.
`default_nettype none

module tzsp_decapsulator_loop_filter #(
  parameter int COUNT_WIDTH  = tzdl_pkg::COUNT_WIDTH_DEF,
  parameter int MAX_DATAGRAM = tzdl_pkg::MAX_DATAGRAM_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [7:0]                         in_data_byte,
  input  wire logic                               in_last_byte,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [7:0]                              out_frame_byte,
  output logic                                    out_frame_valid,
  output logic                                    out_datagram_done,
  output logic [2:0]                              out_verdict,
  output logic [tzdl_pkg::SHOW_W-1:0]             out_forwarded_total,
  output logic [tzdl_pkg::SHOW_W-1:0]             out_filtered_total,
  input  wire logic                               cfg_we,
  input  wire logic [tzdl_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [tzdl_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import tzdl_pkg::*;

  logic        port_we;
  logic [15:0] loop_port_r;
  logic        filter_on_r;

  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        in_last_r;

  logic        out_valid_r;
  tzdl_res_t   res_r;
  logic [SHOW_W-1:0] fwd_r, filt_r;

  logic        in_acc;
  logic        adv;
  logic        step;
  tzdl_res_t   res;
  tzdl_evt_t   evt;
  logic [SHOW_W-1:0] fwd_show, filt_show;

  assign adv      = !out_valid_r || !out_stall;
  assign step     = in_valid_r && adv;
  assign in_stall = in_valid_r && !adv;
  assign in_acc   = in_valid && !in_stall;
  assign port_we  = cfg_we && (cfg_index == REG_LOOP_PORT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_port_r <= LOOP_PORT_RST;
      filter_on_r <= LOOP_FILTER_ON_RST;
    end else begin
      if (port_we) loop_port_r <= cfg_data[15:0];
      if (cfg_we && cfg_index == REG_LOOP_FILTER_ON) filter_on_r <= cfg_data[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        in_valid_r <= 1'b1;
      end else if (step) begin
        in_valid_r <= 1'b0;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (adv) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_byte_r <= in_data_byte;
      in_last_r <= in_last_byte;
    end
    if (step) begin
      res_r  <= res;
      fwd_r  <= fwd_show;
      filt_r <= filt_show;
    end
  end

  tzdl_parse #(
    .MAX_DATAGRAM(MAX_DATAGRAM)
  ) u_parse (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (step),
    .data_byte      (in_byte_r),
    .last_byte      (in_last_r),
    .loop_port      (loop_port_r),
    .loop_filter_on (filter_on_r),
    .res            (res),
    .evt            (evt)
  );

  tzdl_count #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_count (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .evt       (evt),
    .fwd_show  (fwd_show),
    .filt_show (filt_show)
  );

  assign out_valid           = out_valid_r;
  assign out_frame_byte      = res_r.frame_byte;
  assign out_frame_valid     = res_r.frame_valid;
  assign out_datagram_done   = res_r.datagram_done;
  assign out_verdict         = res_r.verdict;
  assign out_forwarded_total = fwd_r;
  assign out_filtered_total  = filt_r;

endmodule

`default_nettype wire

[sv/tzdl_parse.sv]
// Header check, tag walk and inner-frame field capture; one byte per step.
// Depends on tzdl_pkg.
`default_nettype none

module tzdl_parse #(
  parameter int MAX_DATAGRAM = tzdl_pkg::MAX_DATAGRAM_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic [7:0]        data_byte,
  input  wire logic              last_byte,
  input  wire logic [15:0]       loop_port,
  input  wire logic              loop_filter_on,
  output tzdl_pkg::tzdl_res_t    res,
  output tzdl_pkg::tzdl_evt_t    evt
);
  import tzdl_pkg::*;

  localparam int BC_W = $clog2(MAX_DATAGRAM + 1);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_TAG_TYPE,
    PH_TAG_LEN,
    PH_TAG_SKIP,
    PH_FRAME,
    PH_HALT
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic [7:0]      ver_r, ver_nxt;
  logic [7:0]      type_r, type_nxt;
  logic [7:0]      skip_r, skip_nxt;
  logic [6:0]      fidx_r, fidx_nxt;
  logic [15:0]     flen_r, flen_nxt;
  logic [15:0]     etype_r, etype_nxt;
  logic [5:0]      ihb_r, ihb_nxt;
  logic [7:0]      proto_r, proto_nxt;
  logic [15:0]     udp_r, udp_nxt;
  logic [BC_W-1:0] bc_r, bc_nxt;

  logic [6:0] udp_off;
  logic [6:0] udp_need;
  logic       is_loop;
  logic       fvalid;
  verdict_t   vd;

  assign udp_off  = ETH_HDR_LEN + 7'(ihb_r);
  assign udp_need = ETH_HDR_LEN + 7'(ihb_nxt) + 7'd4;

  always_comb begin
    phase_nxt = phase_r;
    ver_nxt   = ver_r;
    type_nxt  = type_r;
    skip_nxt  = skip_r;
    fidx_nxt  = fidx_r;
    flen_nxt  = flen_r;
    etype_nxt = etype_r;
    ihb_nxt   = ihb_r;
    proto_nxt = proto_r;
    udp_nxt   = udp_r;
    bc_nxt    = bc_r;
    fvalid    = 1'b0;

    if (bc_r < BC_W'(MAX_DATAGRAM)) begin
      bc_nxt = bc_r + 1'b1;
      case (phase_r)
        PH_HEADER: begin
          if (fidx_r == 7'd0) begin
            ver_nxt = data_byte;
          end else if (fidx_r == 7'd1) begin
            type_nxt = data_byte;
          end
          if (fidx_r >= HDR_LAST_IDX) begin
            fidx_nxt = '0;
            if (ver_r != TZSP_VERSION || type_r > TZSP_TYPE_MAX) begin
              phase_nxt = PH_HALT;
            end else begin
              phase_nxt = PH_TAG_TYPE;
            end
          end else begin
            fidx_nxt = fidx_r + 7'd1;
          end
        end
        PH_TAG_TYPE: begin
          if (data_byte == TAG_END) begin
            phase_nxt = PH_FRAME;
          end else if (data_byte != TAG_PAD) begin
            phase_nxt = PH_TAG_LEN;
          end
        end
        PH_TAG_LEN: begin
          skip_nxt  = data_byte;
          phase_nxt = (data_byte == 8'd0) ? PH_TAG_TYPE : PH_TAG_SKIP;
        end
        PH_TAG_SKIP: begin
          if (skip_r != 8'd0) begin
            skip_nxt = skip_r - 8'd1;
          end
          if (skip_r <= 8'd1) begin
            phase_nxt = PH_TAG_TYPE;
          end
        end
        PH_FRAME: begin
          fvalid = 1'b1;
          if (fidx_r == IDX_ETYPE_HI) etype_nxt[15:8] = data_byte;
          if (fidx_r == IDX_ETYPE_LO) etype_nxt[7:0] = data_byte;
          if (fidx_r == IDX_IHL) ihb_nxt = {data_byte[3:0] & IHL_MASK, 2'b00};
          if (fidx_r == IDX_PROTO) proto_nxt = data_byte;
          if (fidx_r == udp_off + 7'd2) udp_nxt[15:8] = data_byte;
          if (fidx_r == udp_off + 7'd3) udp_nxt[7:0] = data_byte;
          if (fidx_r != '1) fidx_nxt = fidx_r + 7'd1;
          if (flen_r != '1) flen_nxt = flen_r + 16'd1;
        end
        default: begin
        end
      endcase
    end

    is_loop = (flen_nxt >= MIN_UDP_FRAME) && (etype_nxt == ETHERTYPE_IPV4) &&
              (proto_nxt == IP_PROTO_UDP) && (flen_nxt >= 16'(udp_need)) &&
              (udp_nxt == loop_port);

    case (phase_nxt)
      PH_HEADER: vd = V_SHORT;
      PH_HALT:   vd = (ver_nxt != TZSP_VERSION) ? V_VERSION : V_TYPE;
      PH_FRAME: begin
        if (flen_nxt == 16'd0) begin
          vd = V_EMPTY;
        end else if (loop_filter_on && is_loop) begin
          vd = V_FILTERED;
        end else begin
          vd = V_FORWARD;
        end
      end
      default:   vd = V_MALFORMED;
    endcase

    res.frame_byte    = fvalid ? data_byte : 8'd0;
    res.frame_valid   = fvalid;
    res.datagram_done = last_byte;
    res.verdict       = last_byte ? vd : V_FORWARD;
    evt.fwd           = last_byte && (vd == V_FORWARD);
    evt.filt          = last_byte && (vd == V_FILTERED);

    if (last_byte) begin
      phase_nxt = PH_HEADER;
      ver_nxt   = '0;
      type_nxt  = '0;
      skip_nxt  = '0;
      fidx_nxt  = '0;
      flen_nxt  = '0;
      etype_nxt = '0;
      ihb_nxt   = '0;
      proto_nxt = '0;
      udp_nxt   = '0;
      bc_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      ver_r   <= '0;
      type_r  <= '0;
      skip_r  <= '0;
      fidx_r  <= '0;
      flen_r  <= '0;
      etype_r <= '0;
      ihb_r   <= '0;
      proto_r <= '0;
      udp_r   <= '0;
      bc_r    <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      ver_r   <= ver_nxt;
      type_r  <= type_nxt;
      skip_r  <= skip_nxt;
      fidx_r  <= fidx_nxt;
      flen_r  <= flen_nxt;
      etype_r <= etype_nxt;
      ihb_r   <= ihb_nxt;
      proto_r <= proto_nxt;
      udp_r   <= udp_nxt;
      bc_r    <= bc_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/tzdl_count.sv]
// Saturating forwarded and filtered frame counters with 32-bit display values.
// Depends on tzdl_pkg.
`default_nettype none

module tzdl_count #(
  parameter int COUNT_WIDTH = tzdl_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          step,
  input  wire tzdl_pkg::tzdl_evt_t           evt,
  output logic [tzdl_pkg::SHOW_W-1:0]        fwd_show,
  output logic [tzdl_pkg::SHOW_W-1:0]        filt_show
);
  import tzdl_pkg::*;

  logic [COUNT_WIDTH-1:0] fwd_r, fwd_nxt;
  logic [COUNT_WIDTH-1:0] filt_r, filt_nxt;

  always_comb begin
    fwd_nxt  = fwd_r;
    filt_nxt = filt_r;
    if (step && evt.fwd && !(&fwd_r)) fwd_nxt = fwd_r + 1'b1;
    if (step && evt.filt && !(&filt_r)) filt_nxt = filt_r + 1'b1;
  end

  generate
    if (COUNT_WIDTH > SHOW_W) begin : g_clip
      assign fwd_show  = (|fwd_nxt[COUNT_WIDTH-1:SHOW_W]) ? '1 : fwd_nxt[SHOW_W-1:0];
      assign filt_show = (|filt_nxt[COUNT_WIDTH-1:SHOW_W]) ? '1 : filt_nxt[SHOW_W-1:0];
    end else begin : g_ext
      assign fwd_show  = SHOW_W'(fwd_nxt);
      assign filt_show = SHOW_W'(filt_nxt);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r  <= '0;
      filt_r <= '0;
    end else begin
      fwd_r  <= fwd_nxt;
      filt_r <= filt_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/tzdl_checker.sv]
// Port-level checks on the result channel of the decapsulator, and the bind
// that attaches them to the top level. Depends on tzdl_pkg.
`default_nettype none

module tzdl_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [7:0]                    out_frame_byte,
  input wire logic                          out_frame_valid,
  input wire logic                          out_datagram_done,
  input wire logic [2:0]                    out_verdict,
  input wire logic [tzdl_pkg::SHOW_W-1:0]   out_forwarded_total,
  input wire logic [tzdl_pkg::SHOW_W-1:0]   out_filtered_total
);
  import tzdl_pkg::*;

  a_byte_zero_outside_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_valid |-> out_frame_byte == 8'd0)
    else $error("frame byte nonzero outside inner frame");

  a_verdict_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_datagram_done |-> out_verdict == V_FORWARD)
    else $error("verdict set on a word that is not the last");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_frame_byte) &&
      $stable(out_frame_valid) && $stable(out_datagram_done) && $stable(out_verdict) &&
      $stable(out_forwarded_total) && $stable(out_filtered_total))
    else $error("stalled result word changed");

  a_fwd_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(out_valid) && out_forwarded_total != $past(out_forwarded_total)
    |-> out_datagram_done && out_verdict == V_FORWARD &&
        out_forwarded_total == $past(out_forwarded_total) + 1'b1)
    else $error("forwarded count moved without a forwarded verdict");

  a_filt_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(out_valid) && out_filtered_total != $past(out_filtered_total)
    |-> out_datagram_done && out_verdict == V_FILTERED &&
        out_filtered_total == $past(out_filtered_total) + 1'b1)
    else $error("filtered count moved without a filtered verdict");

endmodule

bind tzsp_decapsulator_loop_filter tzdl_checker u_tzdl_checker (.*);

`default_nettype wire
